>>> hdl/round_robin_time_slice_scheduler_macros.svh
// Assertion macros for the round-robin time-slice scheduler.
`ifndef ROUND_ROBIN_TIME_SLICE_SCHEDULER_MACROS_SVH
`define ROUND_ROBIN_TIME_SLICE_SCHEDULER_MACROS_SVH
`ifndef SYNTHESIS
// Same-cycle implication, sampled on clk, disabled in reset.
`define RRTS_ASSERT_SAME(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);
// Next-cycle implication, sampled on clk, disabled in reset.
`define RRTS_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);
`else
`define RRTS_ASSERT_SAME(lbl, ante, cons, msg)
`define RRTS_ASSERT_NEXT(lbl, ante, cons, msg)
`endif
`endif

>>> hdl/rrts_pkg.sv
// Shared types and constants of the round-robin time-slice scheduler.
`timescale 1ns / 1ps
package rrts_pkg;

  localparam int RRTS_MAX_PROCS  = 32;
  localparam int RRTS_BURST_BITS = 16;

  localparam int ID_W       = 5;
  localparam int IN_BURST_W = 16;
  localparam int EVENT_W    = 3;
  localparam int TIME_W     = 32;
  localparam int REM_W      = 16;
  localparam int SLICE_W    = 16;
  localparam int CFG_DATA_W = 32;
  localparam int CFG_IDX_W  = 1;

  // item kinds
  localparam logic FUNC_ARRIVE = 1'b0;
  localparam logic FUNC_TICK   = 1'b1;

  // result events
  localparam logic [EVENT_W-1:0] EV_IDLE     = 3'd0;
  localparam logic [EVENT_W-1:0] EV_RAN      = 3'd1;
  localparam logic [EVENT_W-1:0] EV_FINISHED = 3'd2;
  localparam logic [EVENT_W-1:0] EV_PREEMPT  = 3'd3;
  localparam logic [EVENT_W-1:0] EV_REJ_FULL = 3'd4;
  localparam logic [EVENT_W-1:0] EV_REJ_ZERO = 3'd5;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_QUANTUM    = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_START_TIME = 1'b1;

  typedef struct packed {
    logic                  func;
    logic [ID_W-1:0]       proc_id;
    logic [IN_BURST_W-1:0] burst;
  } in_item_t;

  typedef struct packed {
    logic [EVENT_W-1:0] event_res;
    logic [ID_W-1:0]    proc_id_res;
    logic [TIME_W-1:0]  now;
    logic [REM_W-1:0]   remaining;
  } out_item_t;

endpackage

>>> hdl/rrts_queue_mem.sv
// Ready-queue storage: one write port, one read port with registered data.
`timescale 1ns / 1ps
module rrts_queue_mem import rrts_pkg::*; #(
  parameter int DEPTH   = RRTS_MAX_PROCS,
  parameter int ADDR_W  = $clog2(RRTS_MAX_PROCS),
  parameter int ENTRY_W = ID_W + RRTS_BURST_BITS
) (
  input  logic               clk,
  input  logic               we,
  input  logic [ADDR_W-1:0]  waddr,
  input  logic [ENTRY_W-1:0] wdata,
  input  logic               re,
  input  logic [ADDR_W-1:0]  raddr,
  output logic [ENTRY_W-1:0] rdata
);

  logic [ENTRY_W-1:0] mem [DEPTH];
  logic [ENTRY_W-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // hold read data until the next read
  always_ff @(posedge clk) begin
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

>>> hdl/rrts_sched_core.sv
// Scheduler control: queue pointers, slice and time counters, result register.
`timescale 1ns / 1ps
module rrts_sched_core import rrts_pkg::*; #(
  parameter int MAX_PROCS  = RRTS_MAX_PROCS,
  parameter int BURST_BITS = RRTS_BURST_BITS,
  parameter int PTR_W      = $clog2(MAX_PROCS),
  parameter int ENTRY_W    = ID_W + BURST_BITS
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  in_item_t           in_data,
  output logic               out_valid,
  input  logic               out_stall,
  output out_item_t          out_data,
  input  logic [SLICE_W-1:0] quantum,
  input  logic [TIME_W-1:0]  start_time,
  output logic               mem_we,
  output logic [PTR_W-1:0]   mem_waddr,
  output logic [ENTRY_W-1:0] mem_wdata,
  output logic               mem_re,
  output logic [PTR_W-1:0]   mem_raddr,
  input  logic [ENTRY_W-1:0] mem_rdata
);

  localparam int CNT_W = $clog2(MAX_PROCS + 1);
  localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(MAX_PROCS - 1);
  localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(MAX_PROCS);

  typedef enum logic [2:0] {
    ST_IDLE = 3'b001,
    ST_EXEC = 3'b010,
    ST_EMIT = 3'b100
  } state_t;

  state_t             state_r, state_nxt;
  logic [PTR_W-1:0]   head_r, head_nxt;
  logic [PTR_W-1:0]   tail_r, tail_nxt;
  logic [CNT_W-1:0]   count_r, count_nxt;
  logic [SLICE_W-1:0] slice_r, slice_nxt;
  logic [TIME_W-1:0]  elapsed_r, elapsed_nxt;
  out_item_t          pend_r, pend_nxt;
  out_item_t          out_r, out_nxt;
  logic               out_valid_r, out_valid_nxt;

  logic                  accept;
  logic                  out_free;
  logic [BURST_BITS-1:0] burst_in;
  logic [TIME_W-1:0]     now_cur;
  logic [ID_W-1:0]       head_id;
  logic [BURST_BITS-1:0] head_rem;
  logic [SLICE_W-1:0]    slice_inc;
  logic [SLICE_W-1:0]    q_eff;
  logic [PTR_W-1:0]      head_adv;
  logic [PTR_W-1:0]      tail_adv;
  out_item_t             res;
  logic                  res_valid;

  assign in_stall = (state_r != ST_IDLE);
  assign accept   = in_valid && !in_stall;
  assign out_free = !out_valid_r || !out_stall;
  assign burst_in = BURST_BITS'(in_data.burst);
  assign now_cur  = start_time + elapsed_r;
  assign head_id  = mem_rdata[ENTRY_W-1 -: ID_W];
  assign head_rem = mem_rdata[BURST_BITS-1:0] - 1'b1;
  assign slice_inc = slice_r + 1'b1;
  assign q_eff    = (quantum == '0) ? SLICE_W'(1) : quantum;
  assign head_adv = (head_r == PTR_LAST) ? '0 : head_r + 1'b1;
  assign tail_adv = (tail_r == PTR_LAST) ? '0 : tail_r + 1'b1;

  always_comb begin
    state_nxt     = state_r;
    head_nxt      = head_r;
    tail_nxt      = tail_r;
    count_nxt     = count_r;
    slice_nxt     = slice_r;
    elapsed_nxt   = elapsed_r;
    pend_nxt      = pend_r;
    out_nxt       = out_r;
    out_valid_nxt = out_valid_r && out_stall;
    mem_we        = 1'b0;
    mem_waddr     = tail_r;
    mem_wdata     = {in_data.proc_id, burst_in};
    mem_re        = 1'b0;
    mem_raddr     = head_r;
    res           = '0;
    res_valid     = 1'b0;

    case (state_r)
      ST_IDLE: begin
        if (accept) begin
          if (in_data.func == FUNC_TICK) begin
            // advance time now, the head entry arrives next cycle
            elapsed_nxt = elapsed_r + 1'b1;
            mem_re      = 1'b1;
            state_nxt   = ST_EXEC;
          end else if (burst_in == '0) begin
            res       = '{EV_REJ_ZERO, in_data.proc_id, now_cur, '0};
            res_valid = 1'b1;
          end else if (count_r == CNT_FULL) begin
            res       = '{EV_REJ_FULL, in_data.proc_id, now_cur, REM_W'(burst_in)};
            res_valid = 1'b1;
          end else begin
            mem_we    = 1'b1;
            tail_nxt  = tail_adv;
            count_nxt = count_r + 1'b1;
          end
        end
      end
      ST_EXEC: begin
        res_valid = 1'b1;
        state_nxt = ST_IDLE;
        if (count_r == '0) begin
          res = '{EV_IDLE, '0, now_cur, '0};
        end else if (head_rem == '0) begin
          // finished: drop from the queue, restart the slice
          head_nxt  = head_adv;
          count_nxt = count_r - 1'b1;
          slice_nxt = '0;
          res       = '{EV_FINISHED, head_id, now_cur, '0};
        end else if (slice_inc >= q_eff) begin
          // quantum used up: rotate head to the tail
          mem_we    = 1'b1;
          mem_waddr = tail_r;
          mem_wdata = {head_id, head_rem};
          head_nxt  = head_adv;
          tail_nxt  = tail_adv;
          slice_nxt = '0;
          res       = '{EV_PREEMPT, head_id, now_cur, REM_W'(head_rem)};
        end else begin
          mem_we    = 1'b1;
          mem_waddr = head_r;
          mem_wdata = {head_id, head_rem};
          slice_nxt = slice_inc;
          res       = '{EV_RAN, head_id, now_cur, REM_W'(head_rem)};
        end
      end
      ST_EMIT: begin
        if (out_free) begin
          out_nxt       = pend_r;
          out_valid_nxt = 1'b1;
          state_nxt     = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase

    // hand the result to the output register, or park it until the sink frees
    if (res_valid) begin
      if (out_free) begin
        out_nxt       = res;
        out_valid_nxt = 1'b1;
        state_nxt     = ST_IDLE;
      end else begin
        pend_nxt  = res;
        state_nxt = ST_EMIT;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      head_r      <= '0;
      tail_r      <= '0;
      count_r     <= '0;
      slice_r     <= '0;
      elapsed_r   <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      head_r      <= head_nxt;
      tail_r      <= tail_nxt;
      count_r     <= count_nxt;
      slice_r     <= slice_nxt;
      elapsed_r   <= elapsed_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    pend_r <= pend_nxt;
    out_r  <= out_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

endmodule

>>> hdl/round_robin_time_slice_scheduler.sv
// Arrival: accepted or silent; a rejection is registered at the output, or parked until the sink frees.
// Tick: the registered read of the head entry from queue memory (ST_IDLE)
// followed by the modify and write-back (ST_EXEC); one item is in work at a time.
// Throughput: one arrival per cycle while the sink keeps up; a new tick waits until the last one is done.
// Reset (rst_n low, synchronous): empty queue, time and slice at zero, quantum 1,
// start time 0; queue memory is not cleared, no clearing pass is needed.
`timescale 1ns / 1ps
`include "round_robin_time_slice_scheduler_macros.svh"
module round_robin_time_slice_scheduler import rrts_pkg::*; #(
  parameter int MAX_PROCS  = RRTS_MAX_PROCS,
  parameter int BURST_BITS = RRTS_BURST_BITS
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  in_item_t              in_data,
  output logic                  out_valid,
  input  logic                  out_stall,
  output out_item_t             out_data,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  localparam int PTR_W   = $clog2(MAX_PROCS);
  localparam int ENTRY_W = ID_W + BURST_BITS;

  logic [SLICE_W-1:0] quantum_r;
  logic [TIME_W-1:0]  start_time_r;

  logic               mem_we;
  logic [PTR_W-1:0]   mem_waddr;
  logic [ENTRY_W-1:0] mem_wdata;
  logic               mem_re;
  logic [PTR_W-1:0]   mem_raddr;
  logic [ENTRY_W-1:0] mem_rdata;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      quantum_r    <= SLICE_W'(1);
      start_time_r <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_QUANTUM:    quantum_r    <= cfg_data[SLICE_W-1:0];
        CFG_START_TIME: start_time_r <= cfg_data[TIME_W-1:0];
        default: begin
        end
      endcase
    end
  end

  rrts_sched_core #(
    .MAX_PROCS  (MAX_PROCS),
    .BURST_BITS (BURST_BITS),
    .PTR_W      (PTR_W),
    .ENTRY_W    (ENTRY_W)
  ) u_core (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .in_data    (in_data),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .out_data   (out_data),
    .quantum    (quantum_r),
    .start_time (start_time_r),
    .mem_we     (mem_we),
    .mem_waddr  (mem_waddr),
    .mem_wdata  (mem_wdata),
    .mem_re     (mem_re),
    .mem_raddr  (mem_raddr),
    .mem_rdata  (mem_rdata)
  );

  rrts_queue_mem #(
    .DEPTH   (MAX_PROCS),
    .ADDR_W  (PTR_W),
    .ENTRY_W (ENTRY_W)
  ) u_queue_mem (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .re    (mem_re),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

  `RRTS_ASSERT_SAME(a_no_rw_overlap, mem_we, !mem_re, "queue memory read and write in one cycle")
  `RRTS_ASSERT_NEXT(a_tick_holds_input, in_valid && !in_stall && in_data.func == FUNC_TICK, in_stall, "input taken while a tick is in work")
  `RRTS_ASSERT_SAME(a_idle_fields, out_valid && out_data.event_res == EV_IDLE, out_data.proc_id_res == '0 && out_data.remaining == '0, "idle tick carries a process")
  `RRTS_ASSERT_NEXT(a_tick_reads_head, in_valid && !in_stall && in_data.func == FUNC_TICK, $past(mem_re), "tick accepted without a head read")

endmodule

>>> tb/sv/round_robin_time_slice_scheduler_checker.sv
// Checker for the round-robin time-slice scheduler: watches both channels, predicts and compares.
`timescale 1ns / 1ps
module round_robin_time_slice_scheduler_checker import rrts_pkg::*; (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  input  logic                  in_stall,
  input  in_item_t              in_data,
  input  logic                  out_valid,
  input  logic                  out_stall,
  input  out_item_t             out_data,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  output int unsigned           fails,
  output int unsigned           pending,
  output int unsigned           occupancy,
  output int unsigned           ticks_owed,
  output int unsigned           results,
  output int unsigned           finished,
  output int unsigned           preempted,
  output int unsigned           rejected,
  output int unsigned           idle_ticks
);

  logic [ID_W-1:0]    ready_id   [RRTS_MAX_PROCS];
  logic [REM_W-1:0]   ready_left [RRTS_MAX_PROCS];
  int unsigned        head, tail, depth, slice_ticks, work_left;
  logic [TIME_W-1:0]  elapsed;
  logic [SLICE_W-1:0] quantum;
  logic [TIME_W-1:0]  start_time;
  out_item_t          due_events [$];
  out_item_t          want;

  function automatic int unsigned next_slot(input int unsigned slot);
    return (slot + 1 == RRTS_MAX_PROCS) ? 0 : slot + 1;
  endfunction

  function automatic out_item_t outcome(input logic [EVENT_W-1:0] ev,
                                        input logic [ID_W-1:0] id,
                                        input logic [TIME_W-1:0] stamp,
                                        input logic [REM_W-1:0] left);
    out_item_t r;
    r.event_res   = ev;
    r.proc_id_res = id;
    r.now         = stamp;
    r.remaining   = left;
    return r;
  endfunction

  // Apply one accepted transfer to the ready queue and queue up the event it causes.
  task automatic schedule_step(input in_item_t item);
    logic [TIME_W-1:0] stamp;
    logic [REM_W-1:0]  left;
    logic [ID_W-1:0]   hid;
    int unsigned       slice_limit;
    if (item.func == FUNC_ARRIVE) begin
      stamp = start_time + elapsed;
      if (item.burst == '0) begin
        due_events.push_back(outcome(EV_REJ_ZERO, item.proc_id, stamp, '0));
      end else if (depth >= RRTS_MAX_PROCS) begin
        due_events.push_back(outcome(EV_REJ_FULL, item.proc_id, stamp, item.burst));
      end else begin
        ready_id[tail]   = item.proc_id;
        ready_left[tail] = item.burst;
        tail             = next_slot(tail);
        depth++;
        work_left += item.burst;
      end
    end else begin
      elapsed = elapsed + 1'b1;
      stamp   = start_time + elapsed;
      if (depth == 0) begin
        due_events.push_back(outcome(EV_IDLE, '0, stamp, '0));
      end else begin
        hid              = ready_id[head];
        left             = ready_left[head] - 1'b1;
        ready_left[head] = left;
        work_left--;
        slice_ticks++;
        slice_limit = (quantum == '0) ? 1 : quantum;
        if (left == '0) begin
          head        = next_slot(head);
          depth--;
          slice_ticks = 0;
          due_events.push_back(outcome(EV_FINISHED, hid, stamp, '0));
        end else if (slice_ticks >= slice_limit) begin
          // rotate the head to the tail; with a full queue both point at one slot
          ready_id[tail]   = hid;
          ready_left[tail] = left;
          head             = next_slot(head);
          tail             = next_slot(tail);
          slice_ticks      = 0;
          due_events.push_back(outcome(EV_PREEMPT, hid, stamp, left));
        end else begin
          due_events.push_back(outcome(EV_RAN, hid, stamp, left));
        end
      end
    end
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      quantum     = 16'd1;
      start_time  = '0;
      elapsed     = '0;
      head        = 0;
      tail        = 0;
      depth       = 0;
      slice_ticks = 0;
      work_left   = 0;
      due_events.delete();
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          CFG_QUANTUM:    quantum = cfg_data[SLICE_W-1:0];
          CFG_START_TIME: start_time = cfg_data[TIME_W-1:0];
          default: ;
        endcase
      end
      if (in_valid && !in_stall) schedule_step(in_data);
      if (out_valid && !out_stall) begin
        if (due_events.size() == 0) begin
          $error("unexpected result: event_res %0d proc_id_res %0d now %0d",
                 out_data.event_res, out_data.proc_id_res, out_data.now);
          fails++;
        end else begin
          want = due_events.pop_front();
          results++;
          case (want.event_res)
            EV_FINISHED:              finished++;
            EV_PREEMPT:               preempted++;
            EV_REJ_FULL, EV_REJ_ZERO: rejected++;
            EV_IDLE:                  idle_ticks++;
            default: ;
          endcase
          if (out_data.event_res !== want.event_res) begin
            $error("event_res: expected %0d, got %0d", want.event_res, out_data.event_res);
            fails++;
          end
          if (out_data.proc_id_res !== want.proc_id_res) begin
            $error("proc_id_res: expected %0d, got %0d", want.proc_id_res,
                   out_data.proc_id_res);
            fails++;
          end
          if (out_data.now !== want.now) begin
            $error("now: expected %0d, got %0d", want.now, out_data.now);
            fails++;
          end
          if (out_data.remaining !== want.remaining) begin
            $error("remaining: expected %0d, got %0d", want.remaining, out_data.remaining);
            fails++;
          end
        end
      end
    end
    pending    <= due_events.size();
    occupancy  <= depth;
    ticks_owed <= work_left;
  end

endmodule

>>> tb/sv/round_robin_time_slice_scheduler_test.sv
// Testbench top for the round-robin time-slice scheduler: stimulus, idling and verdict.
`timescale 1ns / 1ps
module round_robin_time_slice_scheduler_test;
  import rrts_pkg::*;

  typedef enum int {IDLE_NONE, IDLE_SEND, IDLE_RECV, IDLE_BOTH} idle_mode_t;

  localparam int HOLD_CYCLES    = 400;
  localparam int SETTLE_CYCLES  = 4;
  localparam int TAIL_CYCLES    = 20;
  localparam int WATCHDOG_LIMIT = 5000;
  localparam int RUN_ITEMS      = 100;

  logic                  clk       = 1'b0;
  logic                  rst_n     = 1'b0;
  logic                  in_valid  = 1'b0;
  logic                  in_stall;
  in_item_t              in_data   = '0;
  logic                  out_valid;
  logic                  out_stall = 1'b0;
  out_item_t             out_data;
  logic                  cfg_we    = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index = CFG_QUANTUM;
  logic [CFG_DATA_W-1:0] cfg_data  = '0;

  int unsigned fails, pending, occupancy, ticks_owed;
  int unsigned results, finished, preempted, rejected, idle_ticks;
  idle_mode_t  idle_mode    = IDLE_NONE;
  int unsigned hold_req     = 0;
  int unsigned hold_seen    = 0;
  int unsigned hold_left    = 0;
  int unsigned quiet_cycles = 0;
  int unsigned items_sent   = 0;

  round_robin_time_slice_scheduler dut (.*);

  round_robin_time_slice_scheduler_checker checker_i (.*);

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Receiver: a requested hold-off takes priority over random stalling.
  always @(posedge clk) begin
    if (!rst_n) begin
      out_stall <= 1'b0;
      hold_left <= 0;
      hold_seen <= 0;
    end else if (hold_left != 0) begin
      out_stall <= 1'b1;
      hold_left <= hold_left - 1;
    end else if (hold_req != hold_seen) begin
      hold_seen <= hold_req;
      hold_left <= HOLD_CYCLES;
      out_stall <= 1'b1;
    end else begin
      case (idle_mode)
        IDLE_RECV: out_stall <= ($urandom_range(99) < 61);
        IDLE_BOTH: out_stall <= ($urandom_range(99) < 38);
        default:   out_stall <= 1'b0;
      endcase
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall) || cfg_we) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
    if (quiet_cycles == WATCHDOG_LIMIT) begin
      $display("timeout after %0d cycles with no transfer", WATCHDOG_LIMIT);
      $display("round_robin_time_slice_scheduler_test NOT OK");
      $finish;
    end
  end

  function automatic bit sender_rests();
    case (idle_mode)
      IDLE_SEND: return $urandom_range(99) < 61;
      IDLE_BOTH: return $urandom_range(99) < 38;
      default:   return 1'b0;
    endcase
  endfunction

  task automatic send_item(input in_item_t item);
    while (sender_rests()) begin
      in_valid <= 1'b0;
      in_data  <= in_item_t'($urandom);
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= item;
    items_sent++;
    do @(posedge clk); while (in_stall);
  endtask

  task automatic arrive(input logic [ID_W-1:0] id, input logic [IN_BURST_W-1:0] burst);
    in_item_t item;
    item.func    = FUNC_ARRIVE;
    item.proc_id = id;
    item.burst   = burst;
    send_item(item);
  endtask

  // Id and burst are don't-care on a tick, so fill them with noise.
  task automatic tick();
    in_item_t item;
    item      = in_item_t'($urandom);
    item.func = FUNC_TICK;
    send_item(item);
  endtask

  task automatic settle();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic set_config(input logic [SLICE_W-1:0] quantum,
                            input logic [TIME_W-1:0] start_time);
    settle();
    cfg_we    <= 1'b1;
    cfg_index <= CFG_QUANTUM;
    cfg_data  <= CFG_DATA_W'(quantum);
    @(posedge clk);
    cfg_index <= CFG_START_TIME;
    cfg_data  <= start_time;
    @(posedge clk);
    cfg_we    <= 1'b0;
  endtask

  task automatic random_run(input int unsigned count);
    int unsigned done_items, batch, total, span, burst_len;
    done_items = 0;
    while (done_items < count) begin
      case ($urandom_range(99)) inside
        [0:64]: begin
          // a few arrivals, then roughly enough ticks to serve them
          batch = $urandom_range(1, 5);
          total = 0;
          repeat (batch) begin
            burst_len = $urandom_range(1, ($urandom_range(3) == 0) ? 40 : 6);
            arrive(ID_W'($urandom), IN_BURST_W'(burst_len));
            total += burst_len;
          end
          span = $urandom_range(total / 2, total + 3);
          repeat (span) tick();
          done_items += batch + span;
        end
        [65:84]: begin
          span = $urandom_range(1, 8);
          repeat (span) tick();
          done_items += span;
        end
        default: begin
          // mixed kinds, zero bursts among them
          span = $urandom_range(1, 4);
          repeat (span) begin
            burst_len = ($urandom_range(2) == 0) ? 0 : $urandom_range(1, 8);
            if ($urandom_range(1) == 0) tick();
            else arrive(ID_W'($urandom), IN_BURST_W'(burst_len));
          end
          done_items += span;
        end
      endcase
    end
  endtask

  // Top the queue up to full, offer arrivals it must refuse, then tick it empty.
  task automatic fill_and_flush();
    int unsigned room, owed, burst_len;
    settle();
    room = RRTS_MAX_PROCS - occupancy;
    repeat (room) arrive(ID_W'($urandom), IN_BURST_W'($urandom_range(1, 4)));
    arrive(ID_W'($urandom), 16'hFFFF);
    repeat ($urandom_range(1, 3)) begin
      burst_len = ($urandom_range(3) == 0) ? 0 : $urandom_range(0, 65535);
      arrive(ID_W'($urandom), IN_BURST_W'(burst_len));
    end
    settle();
    owed = ticks_owed;
    repeat (owed + $urandom_range(1, 3)) tick();
  endtask

  task automatic run_phase(input idle_mode_t mode, input logic [SLICE_W-1:0] quantum,
                           input logic [TIME_W-1:0] start_time, input bit with_hold);
    set_config(quantum, start_time);
    idle_mode <= mode;
    if (with_hold) hold_req <= hold_req + 1;
    random_run(RUN_ITEMS);
    fill_and_flush();
    random_run(RUN_ITEMS);
  endtask

  initial begin
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;

    // reset settings: quantum 1, time from zero
    tick();
    arrive(5'd0, 16'd0);
    arrive(5'd31, 16'd1);
    tick();
    arrive(5'd7, 16'd3);
    arrive(5'd12, 16'd2);
    repeat (5) tick();

    // zero quantum acts as one; time wraps past the top
    set_config(16'd0, 32'hFFFF_FFFE);
    arrive(5'd3, 16'd2);
    arrive(5'd21, 16'd1);
    repeat (4) tick();

    // longer slice: runs before the preemption
    set_config(16'd4, 32'h1234_5678);
    arrive(5'd9, 16'd5);
    arrive(5'd10, 16'd1);
    repeat (6) tick();

    run_phase(IDLE_NONE, 16'd2, $urandom, 1'b1);
    run_phase(IDLE_SEND, 16'hFFFF, 32'h0, 1'b0);
    run_phase(IDLE_RECV, 16'd1, 32'hFFFF_FFFF, 1'b1);
    run_phase(IDLE_BOTH, SLICE_W'($urandom_range(1, 6)), 32'hFFFF_FF00, 1'b0);

    settle();
    repeat (TAIL_CYCLES) @(posedge clk);
    $display("%0d items over four idling modes, quanta 0 to 65535, time wrap and full queues",
             items_sent);
    $display("%0d results checked: %0d finished, %0d preempted, %0d rejected, %0d idle ticks",
             results, finished, preempted, rejected, idle_ticks);
    if (fails == 0 && pending == 0) begin
      $display("round_robin_time_slice_scheduler_test OK");
    end else begin
      $display("round_robin_time_slice_scheduler_test NOT OK");
    end
    $finish;
  end

endmodule

>>> round_robin_time_slice_scheduler.f
+incdir+hdl
hdl/rrts_pkg.sv
hdl/rrts_queue_mem.sv
hdl/rrts_sched_core.sv
hdl/round_robin_time_slice_scheduler.sv
tb/sv/round_robin_time_slice_scheduler_checker.sv
tb/sv/round_robin_time_slice_scheduler_test.sv
